// File: hw/rtl/bsa_pkg.sv
// bsa_pkg: field widths, status codes, request codes and register indexes
// for the bitmap slot allocator. No dependencies.
package bsa_pkg;

    localparam int SLOT_W      = 8;
    localparam int OFF_W       = 25;
    localparam int USED_W      = 9;
    localparam int CNT_CFG_W   = 9;
    localparam int OBJ_W       = 16;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_ALLOC = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_NIBLETS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_ENABLE     = 2'd2;

    localparam logic [CNT_CFG_W-1:0] SLOT_COUNT_RST     = 9'd256;
    localparam logic [OBJ_W-1:0]     OBJECT_NIBLETS_RST = 16'd1;
    localparam logic                 PAD_ENABLE_RST     = 1'b0;

endpackage

// File: hw/rtl/bitmap_slot_allocator.sv
// bitmap_slot_allocator: single-slab slot allocator over a word-wide bitmap memory.
// Depends on bsa_pkg for field widths, status codes and register indexes.
// One module: sequencer, bitmap memory, reciprocal divide step and offset multiply.

// One request is handled at a time. After reset the bitmap memory is swept to zero,
// one word a cycle, before the first request is taken. An allocate with a full slab
// or a free out of range goes from S_IDLE straight to S_DONE. A free of a clear slot,
// or an allocate whose scan finds no free slot, passes S_DIV1, S_DIV2, S_READ, S_EVAL
// and S_DONE; any other request also passes S_UPD before S_DONE. An allocate repeats
// S_READ and S_EVAL for every further bitmap word it scans, since the scan reads one
// word per pass through the single memory read port. The next request is taken in
// S_IDLE, which is entered as the result is loaded. A finished result waits in the
// output register, and the next request is taken while it waits; a later result
// holds until that register is free.
module bitmap_slot_allocator
    import bsa_pkg::*;
#(
    parameter int MAX_SLOTS = 256,
    parameter int WORD_BITS = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // slot_index[7:0]
    input  logic                   s_axis_tuser,   // req_type[0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // granted_slot[7:0], niblet_offset[32:8],
                                                   // used_slots[41:33], zero[47:42]
    output logic [STATUS_W-1:0]    m_axis_tuser,   // status[1:0]
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int NUM_WORDS = MAX_SLOTS / WORD_BITS;
    localparam int WI_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int CNT_W     = ($clog2(MAX_SLOTS) + 1 > CNT_CFG_W) ?
                               $clog2(MAX_SLOTS) + 1 : CNT_CFG_W;
    localparam int SH        = CNT_W + 8;
    localparam longint RECIP = (longint'(1) << SH) / WORD_BITS;
    localparam int DPROD_W   = CNT_W + SH;
    localparam int STORE_W   = OBJ_W + 1;
    localparam int OPROD_W   = STORE_W + CNT_W;

    localparam logic [CNT_W-1:0]     WB_C      = CNT_W'(WORD_BITS);
    localparam logic [CNT_W-1:0]     MAX_C     = CNT_W'(MAX_SLOTS);
    localparam logic [WORD_BITS-1:0] WORD_FULL = ~(WORD_BITS'(0));
    localparam logic [WI_W-1:0]      LAST_WORD = WI_W'(NUM_WORDS - 1);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b00000001,
        S_IDLE  = 8'b00000010,
        S_DIV1  = 8'b00000100,
        S_DIV2  = 8'b00001000,
        S_READ  = 8'b00010000,
        S_EVAL  = 8'b00100000,
        S_UPD   = 8'b01000000,
        S_DONE  = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    logic [WORD_BITS-1:0] mem [NUM_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 mem_we;
    logic [WI_W-1:0]      mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;

    logic [CNT_CFG_W-1:0] slot_count_reg;
    logic [OBJ_W-1:0]     object_niblets_reg;
    logic                 pad_enable_reg;

    logic [WI_W-1:0]      clr_reg;
    logic [CNT_W-1:0]     hint_slot_reg;
    logic                 hint_exact_reg;
    logic [USED_W-1:0]    used_reg;

    logic                 req_free_reg;
    logic [CNT_W-1:0]     div_x_reg;
    logic [CNT_W-1:0]     q_reg;
    logic                 hint_ok_reg;
    logic                 first_reg;
    logic [WI_W-1:0]      w_reg;
    logic [WI_W-1:0]      start_w_reg;
    logic [CNT_W-1:0]     base_reg;
    logic [BIT_W-1:0]     bit_reg;
    logic [WORD_BITS-1:0] word_reg;
    logic [CNT_W-1:0]     slot_reg;
    status_t              res_status_reg;
    logic [OFF_W-1:0]     res_off_reg;

    logic                 m_valid_reg;
    status_t              m_status_reg;
    logic [SLOT_W-1:0]    m_slot_reg;
    logic [OFF_W-1:0]     m_off_reg;
    logic [USED_W-1:0]    m_used_reg;

    logic                 in_xfer;
    logic [CNT_W-1:0]     cap;
    logic [DPROD_W-1:0]   div_prod;
    logic [CNT_W-1:0]     qwb;
    logic [CNT_W-1:0]     rem_raw;
    logic                 rem_corr;
    logic [CNT_W-1:0]     rem_fix;
    logic [CNT_W-1:0]     q_fix;
    logic [CNT_W-1:0]     base_fix;
    logic                 start_wrap;
    logic [WORD_BITS-1:0] iso_rd;
    logic [BIT_W-1:0]     fc_rd;
    logic [WORD_BITS-1:0] iso_wd;
    logic [BIT_W-1:0]     fc_wd;
    logic [WORD_BITS-1:0] bit_mask;
    logic [CNT_W-1:0]     cand;
    logic                 hint_hit;
    logic                 scan_hit;
    logic [CNT_W-1:0]     nbase;
    logic                 scan_wrap;
    logic [WI_W-1:0]      next_w;
    logic                 scan_done;
    logic [STORE_W-1:0]   store;
    logic [OPROD_W-1:0]   off_prod;
    logic                 out_free;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign cap = (CNT_W'(slot_count_reg) > MAX_C) ? MAX_C : CNT_W'(slot_count_reg);

    // reciprocal divide by the word size, one correction step
    assign div_prod = DPROD_W'(div_x_reg) * DPROD_W'(RECIP);
    assign qwb      = CNT_W'(q_reg * WB_C);
    assign rem_raw  = div_x_reg - qwb;
    assign rem_corr = (rem_raw >= WB_C);
    assign rem_fix  = rem_corr ? rem_raw - WB_C : rem_raw;
    assign q_fix    = rem_corr ? q_reg + CNT_W'(1) : q_reg;
    assign base_fix = div_x_reg - rem_fix;
    assign start_wrap = (req_free_reg == REQ_ALLOC) && (base_fix >= cap);

    // lowest clear bit of the read word and of the updated word
    assign iso_rd = ~rd_data_reg & (rd_data_reg + WORD_BITS'(1));
    assign iso_wd = ~word_reg & (word_reg + WORD_BITS'(1));

    always_comb
    begin
        fc_rd = '0;
        fc_wd = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            fc_rd = fc_rd | (iso_rd[i] ? BIT_W'(i) : BIT_W'(0));
            fc_wd = fc_wd | (iso_wd[i] ? BIT_W'(i) : BIT_W'(0));
        end
    end

    assign bit_mask  = WORD_BITS'(1) << bit_reg;
    assign cand      = base_reg + CNT_W'(fc_rd);
    assign hint_hit  = first_reg && hint_ok_reg && !rd_data_reg[bit_reg];
    assign scan_hit  = (rd_data_reg != WORD_FULL) && (cand < cap);
    assign nbase     = base_reg + WB_C;
    assign scan_wrap = (nbase >= cap);
    assign next_w    = scan_wrap ? WI_W'(0) : w_reg + WI_W'(1);
    assign scan_done = (next_w == start_w_reg);

    assign store    = STORE_W'(object_niblets_reg) + STORE_W'({pad_enable_reg, 1'b0});
    assign off_prod = OPROD_W'(store) * OPROD_W'(slot_reg) + OPROD_W'(pad_enable_reg);

    assign mem_we    = (state_reg == S_CLEAR) || (state_reg == S_UPD);
    assign mem_waddr = (state_reg == S_CLEAR) ? clr_reg : w_reg;
    assign mem_wdata = (state_reg == S_CLEAR) ? WORD_BITS'(0) : word_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == LAST_WORD)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (s_axis_tuser == REQ_ALLOC)
                    begin
                        state_next = (CNT_W'(used_reg) >= cap) ? S_DONE : S_DIV1;
                    end
                    else
                    begin
                        state_next = (CNT_W'(s_axis_tdata) >= cap) ? S_DONE : S_DIV1;
                    end
                end
            end
            S_DIV1: state_next = S_DIV2;
            S_DIV2: state_next = S_READ;
            S_READ: state_next = S_EVAL;
            S_EVAL:
            begin
                if (req_free_reg == REQ_FREE)
                begin
                    state_next = rd_data_reg[bit_reg] ? S_UPD : S_DONE;
                end
                else if (hint_hit || scan_hit)
                begin
                    state_next = S_UPD;
                end
                else
                begin
                    state_next = scan_done ? S_DONE : S_READ;
                end
            end
            S_UPD: state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_CLEAR;
            clr_reg            <= '0;
            hint_slot_reg      <= '0;
            hint_exact_reg     <= 1'b1;
            used_reg           <= '0;
            slot_count_reg     <= SLOT_COUNT_RST;
            object_niblets_reg <= OBJECT_NIBLETS_RST;
            pad_enable_reg     <= PAD_ENABLE_RST;
            m_valid_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + WI_W'(1);
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SLOT_COUNT:     slot_count_reg     <= cfg_data[CNT_CFG_W-1:0];
                    CFG_OBJECT_NIBLETS: object_niblets_reg <= cfg_data[OBJ_W-1:0];
                    CFG_PAD_ENABLE:     pad_enable_reg     <= cfg_data[0];
                    default:            ;
                endcase
            end
            if (state_reg == S_UPD)
            begin
                if (req_free_reg == REQ_ALLOC)
                begin
                    used_reg <= used_reg + USED_W'(1);
                    if (word_reg == WORD_FULL)
                    begin
                        hint_slot_reg  <= base_reg + WB_C;
                        hint_exact_reg <= 1'b0;
                    end
                    else
                    begin
                        hint_slot_reg  <= base_reg + CNT_W'(fc_wd);
                        hint_exact_reg <= 1'b1;
                    end
                end
                else
                begin
                    if (used_reg != '0)
                    begin
                        used_reg <= used_reg - USED_W'(1);
                    end
                    if (!hint_exact_reg || hint_slot_reg > slot_reg)
                    begin
                        hint_slot_reg  <= slot_reg;
                        hint_exact_reg <= 1'b1;
                    end
                end
            end
            if (state_reg == S_DONE && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_valid_reg && m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    req_free_reg   <= s_axis_tuser;
                    hint_ok_reg    <= hint_exact_reg && (hint_slot_reg < cap);
                    div_x_reg      <= (s_axis_tuser == REQ_ALLOC) ? hint_slot_reg
                                                                  : CNT_W'(s_axis_tdata);
                    res_off_reg    <= '0;
                    if (s_axis_tuser == REQ_ALLOC)
                    begin
                        res_status_reg <= ST_FULL;
                        slot_reg       <= '0;
                    end
                    else
                    begin
                        res_status_reg <= ST_RANGE;
                        slot_reg       <= CNT_W'(s_axis_tdata);
                    end
                end
            end
            S_DIV1:
            begin
                q_reg <= div_prod[SH +: CNT_W];
            end
            S_DIV2:
            begin
                bit_reg   <= rem_fix[BIT_W-1:0];
                first_reg <= 1'b1;
                if (start_wrap)
                begin
                    w_reg       <= '0;
                    start_w_reg <= '0;
                    base_reg    <= '0;
                end
                else
                begin
                    w_reg       <= q_fix[WI_W-1:0];
                    start_w_reg <= q_fix[WI_W-1:0];
                    base_reg    <= base_fix;
                end
            end
            S_EVAL:
            begin
                if (req_free_reg == REQ_FREE)
                begin
                    word_reg       <= rd_data_reg & ~bit_mask;
                    res_status_reg <= ST_NOT_ALLOC;
                end
                else if (hint_hit)
                begin
                    word_reg <= rd_data_reg | bit_mask;
                    slot_reg <= base_reg + CNT_W'(bit_reg);
                end
                else if (scan_hit)
                begin
                    word_reg <= rd_data_reg | iso_rd;
                    slot_reg <= cand;
                end
                else
                begin
                    first_reg <= 1'b0;
                    w_reg     <= next_w;
                    base_reg  <= scan_wrap ? CNT_W'(0) : nbase;
                end
            end
            S_UPD:
            begin
                res_status_reg <= ST_OK;
                res_off_reg    <= off_prod[OFF_W-1:0];
            end
            default: ;
        endcase

        if (state_reg == S_DONE && out_free)
        begin
            m_status_reg <= res_status_reg;
            m_slot_reg   <= slot_reg[SLOT_W-1:0];
            m_off_reg    <= res_off_reg;
            m_used_reg   <= used_reg;
        end
    end

    // bitmap memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == S_READ)
        begin
            rd_data_reg <= mem[w_reg];
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - USED_W - OFF_W - SLOT_W)'(0),
                            m_used_reg, m_off_reg, m_slot_reg};

    // an allocate sets exactly one bit of the word it read
    a_alloc_one_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD && req_free_reg == REQ_ALLOC) |->
        ($countones(word_reg) == $countones(rd_data_reg) + 1))
        else $error("allocate did not set exactly one bitmap bit");

    // a free clears exactly one bit of the word it read
    a_free_one_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD && req_free_reg == REQ_FREE) |->
        ($countones(word_reg) + 1 == $countones(rd_data_reg)))
        else $error("free did not clear exactly one bitmap bit");

    // an exact hint always names a slot inside the bitmap
    a_hint_range: assert property (@(posedge clk) disable iff (!rst_n)
        hint_exact_reg |-> (hint_slot_reg < MAX_C))
        else $error("exact hint outside the bitmap");

    // a finished result reaches the output register once it is free
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !m_valid_reg) |=> (m_valid_reg && state_reg == S_IDLE))
        else $error("finished result not loaded into the output register");

endmodule
